### src/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types and constants of the space vector PWM generator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // default geometry
  localparam int SINE_DEPTH_DEF = 1024;
  localparam int ANGLE_BITS_DEF = 16;

  // field widths
  localparam int CMP_W      = 17;
  localparam int SECTOR_W   = 3;
  localparam int STEP_W     = 16;
  localparam int MOD_W      = 16;
  localparam int PERIOD_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int SINE_W     = 16;

  // fixed point constants
  localparam logic [63:0]         PI_Q30      = 64'd3373259426;
  localparam int                  ONE_Q15     = 32768;
  localparam logic [SECTOR_W-1:0] LAST_SECTOR = 3'd5;
  localparam int                  ZERO_SPLIT  = 2;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 17'd65536;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_INDEX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_COUNT = 2'd2;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } svpwm_cfg_t;

  // datapath commands, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ADVANCE,
    OP_INDEX,
    OP_READ_B,
    OP_MUL_B,
    OP_MUL_A,
    OP_DUTY,
    OP_SCALE_U,
    OP_SCALE_V,
    OP_SCALE_W,
    OP_LOAD
  } svpwm_op_e;

endpackage

### src/svpwm_if.sv
// ----------------------------------------------------------------------------
// svpwm_if
// Valid/ready channels of the space vector PWM generator: tick in, compares out.
// ----------------------------------------------------------------------------
interface svpwm_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface svpwm_out_if import svpwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMP_W-1:0]    compare_u;
  logic [CMP_W-1:0]    compare_v;
  logic [CMP_W-1:0]    compare_w;
  logic [SECTOR_W-1:0] sector;

  modport source (output valid, output compare_u, output compare_v, output compare_w,
                  output sector, input ready);
  modport sink (input valid, input compare_u, input compare_v, input compare_w,
                input sector, output ready);
endinterface

### src/svpwm_ctrl.sv
// ----------------------------------------------------------------------------
// svpwm_ctrl
// Sequencer: steps the datapath through one switching period per tick beat
// and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module svpwm_ctrl import svpwm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_tick_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output svpwm_op_e op_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_INDEX,
    ST_READ_B,
    ST_MUL_B,
    ST_MUL_A,
    ST_DUTY,
    ST_SCALE_U,
    ST_SCALE_V,
    ST_SCALE_W,
    ST_LOAD
  } ctrl_state_e;

  ctrl_state_e state_q;
  logic        out_valid_q;
  logic        load;

  // result register is free once its beat has gone or is going now
  assign load        = (state_q == ST_LOAD) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    unique case (state_q)
      ST_ADVANCE: op_o = OP_ADVANCE;
      ST_INDEX:   op_o = OP_INDEX;
      ST_READ_B:  op_o = OP_READ_B;
      ST_MUL_B:   op_o = OP_MUL_B;
      ST_MUL_A:   op_o = OP_MUL_A;
      ST_DUTY:    op_o = OP_DUTY;
      ST_SCALE_U: op_o = OP_SCALE_U;
      ST_SCALE_V: op_o = OP_SCALE_V;
      ST_SCALE_W: op_o = OP_SCALE_W;
      ST_LOAD:    op_o = load ? OP_LOAD : OP_NONE;
      default:    op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          // a beat without tick is taken and dropped
          if (in_valid_i && in_tick_i) begin
            state_q <= ST_ADVANCE;
          end
        end
        ST_ADVANCE: state_q <= ST_INDEX;
        ST_INDEX:   state_q <= ST_READ_B;
        ST_READ_B:  state_q <= ST_MUL_B;
        ST_MUL_B:   state_q <= ST_MUL_A;
        ST_MUL_A:   state_q <= ST_DUTY;
        ST_DUTY:    state_q <= ST_SCALE_U;
        ST_SCALE_U: state_q <= ST_SCALE_V;
        ST_SCALE_V: state_q <= ST_SCALE_W;
        ST_SCALE_W: state_q <= ST_LOAD;
        ST_LOAD: begin
          if (load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/svpwm_dp.sv
// ----------------------------------------------------------------------------
// svpwm_dp
// Datapath: angle accumulator, sector counter, sine ROM, one shared
// multiplier, zero-time split, sector table and result registers.
// ----------------------------------------------------------------------------
module svpwm_dp import svpwm_pkg::*; #(
  parameter int SINE_DEPTH = SINE_DEPTH_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  svpwm_cfg_t          cfg_i,
  input  svpwm_op_e           op_i,
  output logic [CMP_W-1:0]    compare_u_o,
  output logic [CMP_W-1:0]    compare_v_o,
  output logic [CMP_W-1:0]    compare_w_o,
  output logic [SECTOR_W-1:0] sector_o
);

  localparam int IdxW     = $clog2(SINE_DEPTH + 1);
  localparam int IdxProdW = ANGLE_BITS + IdxW;
  localparam int StepExtW = (ANGLE_BITS > STEP_W) ? ANGLE_BITS : STEP_W;
  localparam logic [63:0] RomDiv = 64'(3 * SINE_DEPTH);
  localparam logic [63:0] TaylorDiv [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
  localparam int DutyW    = 16;
  localparam int RawW     = 19;
  localparam int MulW     = 17;

  typedef logic [SINE_W-1:0] rom_t [0:SINE_DEPTH];

  // sin(k*pi/(3*depth)) by truncated Taylor series in Q30, rounded to Q15
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x    = (64'(k) * PI_Q30) / RomDiv;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        term = term / TaylorDiv[n];
        if (n % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      rom[k] = SINE_W'((acc * 64'd32768 + 64'd536870912) >> 30);
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  function automatic logic [DutyW-1:0] sat_duty(input logic [RawW-1:0] raw);
    logic [DutyW-1:0] res;
    if (raw > RawW'(ONE_Q15)) begin
      res = DutyW'(ONE_Q15);
    end else begin
      res = raw[DutyW-1:0];
    end
    return res;
  endfunction

  // configuration
  logic [STEP_W-1:0]   phase_step_q;
  logic [MOD_W-1:0]    mod_index_q;
  logic [PERIOD_W-1:0] period_q;

  // state
  logic [ANGLE_BITS-1:0] angle_q;
  logic [SECTOR_W-1:0]   sector_q;

  // work registers
  logic [IdxW-1:0]   idx_b_q;
  logic [SINE_W-1:0] rom_q;
  logic [MulW-1:0]   ta_q;
  logic [MulW-1:0]   tb_q;
  logic [DutyW-1:0]  duty_u_q;
  logic [DutyW-1:0]  duty_v_q;
  logic [DutyW-1:0]  duty_w_q;
  logic [CMP_W-1:0]  res_u_q;
  logic [CMP_W-1:0]  res_v_q;
  logic [CMP_W-1:0]  res_w_q;

  // angle step
  logic [StepExtW-1:0]   step_ext;
  logic [ANGLE_BITS-1:0] step_a;
  logic [ANGLE_BITS:0]   adv_sum;
  logic [SECTOR_W-1:0]   sector_next;

  assign step_ext    = StepExtW'(phase_step_q);
  assign step_a      = step_ext[ANGLE_BITS-1:0];
  assign adv_sum     = {1'b0, angle_q} + {1'b0, step_a};
  assign sector_next = (sector_q >= LAST_SECTOR) ? '0 : sector_q + 3'd1;

  // ROM indexes
  logic [IdxProdW-1:0] idx_prod;
  logic [IdxW-1:0]     idx_a;
  logic [IdxW-1:0]     rom_addr;

  assign idx_prod = IdxProdW'(angle_q) * IdxProdW'(SINE_DEPTH);
  assign idx_a    = IdxW'(SINE_DEPTH) - idx_b_q;
  assign rom_addr = (op_i == OP_READ_B) ? idx_b_q : idx_a;

  // shared multiplier, Q15 result
  logic [MulW-1:0]   mul_a;
  logic [MulW-1:0]   mul_b;
  logic [2*MulW-1:0] mul_prod;
  logic [MulW-1:0]   mul_res;
  logic [PERIOD_W-1:0] per;

  assign per      = (period_q > PERIOD_MAX) ? PERIOD_MAX : period_q;
  assign mul_prod = mul_a * mul_b;
  assign mul_res  = mul_prod[MulW+14:15];

  always_comb begin
    unique case (op_i)
      OP_MUL_B, OP_MUL_A: begin
        mul_a = {1'b0, mod_index_q};
        mul_b = {1'b0, rom_q};
      end
      OP_SCALE_U: begin
        mul_a = {1'b0, duty_u_q};
        mul_b = per;
      end
      OP_SCALE_V: begin
        mul_a = {1'b0, duty_v_q};
        mul_b = per;
      end
      OP_SCALE_W: begin
        mul_a = {1'b0, duty_w_q};
        mul_b = per;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // zero time and sector table
  logic [MulW:0]    t_all;
  logic [14:0]      t_zero;
  logic [RawW-1:0]  d_all;
  logic [RawW-1:0]  d_a;
  logic [RawW-1:0]  d_b;
  logic [RawW-1:0]  d_o;
  logic [RawW-1:0]  raw_u;
  logic [RawW-1:0]  raw_v;
  logic [RawW-1:0]  raw_w;

  assign t_all  = {1'b0, ta_q} + {1'b0, tb_q};
  // over-modulated: no zero vector left
  assign t_zero = (t_all < (MulW+1)'(ONE_Q15)) ?
                  15'(((MulW+1)'(ONE_Q15) - t_all) / ZERO_SPLIT) : '0;
  assign d_o    = RawW'(t_zero);
  assign d_all  = RawW'(t_all) + d_o;
  assign d_a    = RawW'(ta_q) + d_o;
  assign d_b    = RawW'(tb_q) + d_o;

  always_comb begin
    unique case (sector_q)
      3'd0: begin
        raw_u = d_all; raw_v = d_b;   raw_w = d_o;
      end
      3'd1: begin
        raw_u = d_a;   raw_v = d_all; raw_w = d_o;
      end
      3'd2: begin
        raw_u = d_o;   raw_v = d_all; raw_w = d_b;
      end
      3'd3: begin
        raw_u = d_o;   raw_v = d_a;   raw_w = d_all;
      end
      3'd4: begin
        raw_u = d_b;   raw_v = d_o;   raw_w = d_all;
      end
      default: begin
        raw_u = d_all; raw_v = d_o;   raw_w = d_a;
      end
    endcase
  end

  // configuration and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      mod_index_q  <= '0;
      period_q     <= PERIOD_MAX;
      angle_q      <= '0;
      sector_q     <= '0;
    end else begin
      if (cfg_i.we) begin
        priority case (cfg_i.idx)
          CFG_PHASE_STEP:   phase_step_q <= cfg_i.data[STEP_W-1:0];
          CFG_MOD_INDEX:    mod_index_q  <= cfg_i.data[MOD_W-1:0];
          CFG_PERIOD_COUNT: period_q     <= cfg_i.data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (op_i == OP_ADVANCE) begin
        angle_q <= adv_sum[ANGLE_BITS-1:0];
        if (adv_sum[ANGLE_BITS]) begin
          sector_q <= sector_next;
        end
      end
    end
  end

  // sine ROM, registered read
  always_ff @(posedge clk_i) begin
    if (op_i == OP_READ_B || op_i == OP_MUL_B) begin
      rom_q <= SineRom[rom_addr];
    end
  end

  // work and result registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_INDEX:   idx_b_q <= IdxW'(idx_prod >> ANGLE_BITS);
      OP_MUL_B:   tb_q    <= mul_res;
      OP_MUL_A:   ta_q    <= mul_res;
      OP_DUTY: begin
        duty_u_q <= sat_duty(raw_u);
        duty_v_q <= sat_duty(raw_v);
        duty_w_q <= sat_duty(raw_w);
      end
      OP_SCALE_U: res_u_q <= mul_res;
      OP_SCALE_V: res_v_q <= mul_res;
      OP_SCALE_W: res_w_q <= mul_res;
      OP_LOAD: begin
        compare_u_o <= res_u_q;
        compare_v_o <= res_v_q;
        compare_w_o <= res_w_q;
        sector_o    <= sector_q;
      end
      default: ;
    endcase
  end

endmodule

### src/space_vector_pwm_generator_unit.sv
// ----------------------------------------------------------------------------
// space_vector_pwm_generator_unit
// Three-phase space vector PWM: each tick beat advances the angle by
// phase_step, moves to the next sector on wrap, and yields three compare
// counts and the sector number. Ready comes back in the cycle the result
// is first offered, so a new tick is taken only once the last one is through.
// The controller walks the datapath through angle update, ROM index, two
// reads of the single-port sine ROM, the duty split and five products on one
// shared multiplier, one step a cycle until the load, which waits for the
// output register to be free.
// A result waiting in the output register does not hold up the next tick
// until that one is ready to be loaded. A beat with tick low yields nothing.
// Write the registers only while no tick is in flight.
// ----------------------------------------------------------------------------
module space_vector_pwm_generator_unit import svpwm_pkg::*; #(
  parameter int SINE_DEPTH = SINE_DEPTH_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  svpwm_in_if.sink              in_i,
  svpwm_out_if.source           out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  svpwm_cfg_t cfg;
  svpwm_op_e  op;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  svpwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_tick_i   (in_i.tick),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .op_o        (op)
  );

  svpwm_dp #(
    .SINE_DEPTH (SINE_DEPTH),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .op_i        (op),
    .compare_u_o (out_o.compare_u),
    .compare_v_o (out_o.compare_v),
    .compare_w_o (out_o.compare_w),
    .sector_o    (out_o.sector)
  );

endmodule

### src/svpwm_chk.sv
// ----------------------------------------------------------------------------
// svpwm_chk
// Port-level checks of the space vector PWM generator, bound to the top level.
// ----------------------------------------------------------------------------
module svpwm_chk import svpwm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                in_tick_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [CMP_W-1:0]    compare_u_i,
  input logic [CMP_W-1:0]    compare_v_i,
  input logic [CMP_W-1:0]    compare_w_i,
  input logic [SECTOR_W-1:0] sector_i
);

  // sector counter never leaves 0..5
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> sector_i <= LAST_SECTOR)
    else $error("sector out of range");

  // saturated duty times clamped period never exceeds a full period
  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (compare_u_i <= CMP_W'(PERIOD_MAX)) && (compare_v_i <= CMP_W'(PERIOD_MAX))
                    && (compare_w_i <= CMP_W'(PERIOD_MAX)))
    else $error("compare above period");

  // a tick beat starts the sequence, so no second beat next cycle
  a_busy_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_tick_i |=> !in_ready_i)
    else $error("ready straight after tick beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(compare_u_i)
      && $stable(compare_v_i) && $stable(compare_w_i) && $stable(sector_i))
    else $error("stalled result beat changed");

endmodule

bind space_vector_pwm_generator_unit svpwm_chk u_svpwm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_tick_i   (in_i.tick),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .compare_u_i (out_o.compare_u),
  .compare_v_i (out_o.compare_v),
  .compare_w_i (out_o.compare_w),
  .sector_i    (out_o.sector)
);
